@@ rtl/abst_pkg.sv @@
// Shared codes and types for the array-backed binary search tree.
package abst_pkg;

    localparam int CFG_W    = 9;
    localparam int STATUS_W = 2;
    localparam int CAP_RESET = 256;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_FIND   = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING  = 2'd3;

    // Write strobes from the sequencer to the node store
    typedef struct packed {
        logic node_we;   // write key, clear both links
        logic left_we;   // link a child on the left
        logic right_we;  // link a child on the right
    } abst_wr_t;

endpackage

@@ rtl/abst_in_if.sv @@
// Command channel: one insert or find request per beat.
interface abst_in_if #(
    parameter int KEY_BITS = 32
);
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic signed [KEY_BITS-1:0] key;

    modport source (output valid, output mode, output key, input ready);
    modport sink   (input valid, input mode, input key, output ready);
endinterface

@@ rtl/abst_out_if.sv @@
// Response channel: one status and slot per beat.
interface abst_out_if #(
    parameter int SLOT_W = 8
);
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;

    modport source (output valid, output status, output slot, input ready);
    modport sink   (input valid, input status, input slot, output ready);
endinterface

@@ rtl/abst_store.sv @@
// Node store: key, left-link and right-link memories with a registered read port.
module abst_store #(
    parameter int MAX_NODES = 256,
    parameter int KEY_BITS  = 32,
    parameter int NODE_W    = 8,
    parameter int LINK_W    = 9
) (
    input  logic                    clk,
    input  abst_pkg::abst_wr_t      wr,
    input  logic [NODE_W-1:0]       wr_addr,
    input  logic [KEY_BITS-1:0]     wr_key,
    input  logic [LINK_W-1:0]       wr_link,
    input  logic                    rd_en,
    input  logic [NODE_W-1:0]       rd_addr,
    output logic [KEY_BITS-1:0]     rd_key,
    output logic [LINK_W-1:0]       rd_left,
    output logic [LINK_W-1:0]       rd_right
);
    import abst_pkg::*;

    localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(MAX_NODES);

    logic [KEY_BITS-1:0] key_mem   [MAX_NODES];
    logic [LINK_W-1:0]   left_mem  [MAX_NODES];
    logic [LINK_W-1:0]   right_mem [MAX_NODES];

    always_ff @(posedge clk)
    begin
        if (wr.node_we)
        begin
            key_mem[wr_addr] <= wr_key;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.node_we)
        begin
            left_mem[wr_addr] <= LINK_NONE;
        end
        else if (wr.left_we)
        begin
            left_mem[wr_addr] <= wr_link;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.node_we)
        begin
            right_mem[wr_addr] <= LINK_NONE;
        end
        else if (wr.right_we)
        begin
            right_mem[wr_addr] <= wr_link;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_key   <= key_mem[rd_addr];
            rd_left  <= left_mem[rd_addr];
            rd_right <= right_mem[rd_addr];
        end
    end

endmodule

@@ rtl/array_bst_insert_search_top.sv @@
// Top level of the array-backed binary search tree: sequencer, comparator and response register.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-----------------------------------------
//  cmd      | in  | valid / ready      | mode (0 insert, 1 find), key (signed)
//  rsp      | out | valid / ready      | status (2 bits), slot
//  cfg      | in  | cfg_we, no stall   | cfg_wdata = capacity, write clears tree
//
//  Steps: accept the beat, then a read and a compare for every node visited on the
//  walk, then move the answer into the response register. Nodes visited: 0 for full,
//  empty or root insert, at most capacity-1 for an insert and capacity for a find.
//  The node store has a single read port.
//  Reset: capacity returns to 256 (or MAX_NODES if smaller) and the tree is empty.
//  Stalls: a new command is taken while the previous answer waits on rsp; a finished
//  walk holds until the response register is free.
module array_bst_insert_search_top #(
    parameter int MAX_NODES = 256,
    parameter int KEY_BITS  = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [abst_pkg::CFG_W-1:0]  cfg_wdata,
    abst_in_if.sink                     cmd,
    abst_out_if.source                  rsp
);
    import abst_pkg::*;

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int CNT_W  = NODE_W + 1;
    localparam logic [CNT_W-1:0] LINK_NONE = CNT_W'(MAX_NODES);
    localparam int RESET_CAP = (MAX_NODES < CAP_RESET) ? MAX_NODES : CAP_RESET;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]                 state_reg,  state_next;
    logic                       mode_reg,   mode_next;
    logic signed [KEY_BITS-1:0] key_reg,    key_next;
    logic [NODE_W-1:0]          cur_reg,    cur_next;
    logic [NODE_W-1:0]          fresh_reg,  fresh_next;
    logic [CNT_W-1:0]           count_reg,  count_next;
    logic [CNT_W-1:0]           cap_reg,    cap_next;
    logic [STATUS_W-1:0]        res_status_reg, res_status_next;
    logic [NODE_W-1:0]          res_slot_reg,   res_slot_next;

    logic                       out_valid_reg;
    logic [STATUS_W-1:0]        out_status_reg;
    logic [NODE_W-1:0]          out_slot_reg;

    // Node store access
    abst_wr_t                   wr;
    logic [NODE_W-1:0]          wr_addr;
    logic [CNT_W-1:0]           wr_link;
    logic                       rd_en;
    logic [KEY_BITS-1:0]        rd_key;
    logic [CNT_W-1:0]           rd_left;
    logic [CNT_W-1:0]           rd_right;

    // Shared compare unit and derived values
    logic [NODE_W-1:0]          root;
    logic [NODE_W-1:0]          fresh;
    logic                       full;
    logic signed [KEY_BITS-1:0] node_key;
    logic                       key_eq;
    logic                       go_right;
    logic [CNT_W-1:0]           link_sel;
    logic                       link_end;
    logic                       load_out;
    logic [31:0]                cfg_wide;
    logic [CNT_W-1:0]           cap_cfg;

    abst_store #(
        .MAX_NODES (MAX_NODES),
        .KEY_BITS  (KEY_BITS),
        .NODE_W    (NODE_W),
        .LINK_W    (CNT_W)
    ) u_store (
        .clk      (clk),
        .wr       (wr),
        .wr_addr  (wr_addr),
        .wr_key   (cmd.key),
        .wr_link  (wr_link),
        .rd_en    (rd_en),
        .rd_addr  (cur_reg),
        .rd_key   (rd_key),
        .rd_left  (rd_left),
        .rd_right (rd_right)
    );

    // Root sits at capacity-1; free slots count down from it
    assign root  = NODE_W'(cap_reg - CNT_W'(1));
    assign fresh = root - count_reg[NODE_W-1:0];
    assign full  = (count_reg >= cap_reg);

    // One signed comparison per visited node. Equal keys go right on insert.
    assign node_key = $signed(rd_key);
    assign key_eq   = (node_key == key_reg);
    assign go_right = (mode_reg == MODE_INSERT) ? !(node_key > key_reg)
                                                : (node_key < key_reg);
    assign link_sel = go_right ? rd_right : rd_left;
    assign link_end = (link_sel == LINK_NONE);

    // Clamp the written capacity into 1 .. MAX_NODES
    assign cfg_wide = 32'(cfg_wdata);
    assign cap_cfg  = (cfg_wide == 32'd0)              ? CNT_W'(1)         :
                      (cfg_wide > 32'(MAX_NODES))      ? CNT_W'(MAX_NODES) :
                                                         CNT_W'(cfg_wide);

    assign load_out  = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);
    assign cmd.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        key_next        = key_reg;
        cur_next        = cur_reg;
        fresh_next      = fresh_reg;
        count_next      = count_reg;
        cap_next        = cap_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        wr              = '0;
        wr_addr         = cur_reg;
        wr_link         = {1'b0, fresh_reg};
        rd_en           = 1'b0;

        // Capacity write: take the new size and drop every node
        if (cfg_we)
        begin
            cap_next   = cap_cfg;
            count_next = '0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    mode_next = cmd.mode;
                    key_next  = cmd.key;
                    cur_next  = root;
                    if (cmd.mode == MODE_INSERT)
                    begin
                        if (full)
                        begin
                            res_status_next = ST_FULL;
                            res_slot_next   = '0;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            // Store the new node now; the walk only has to link it
                            wr.node_we      = 1'b1;
                            wr_addr         = fresh;
                            fresh_next      = fresh;
                            count_next      = count_reg + CNT_W'(1);
                            res_status_next = ST_INSERTED;
                            res_slot_next   = fresh;
                            state_next      = (fresh == root) ? S_DONE : S_READ;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        res_status_next = ST_MISSING;
                        res_slot_next   = '0;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end

            S_READ:
            begin
                rd_en      = 1'b1;
                state_next = S_CMP;
            end

            S_CMP:
            begin
                if ((mode_reg == MODE_FIND) && key_eq)
                begin
                    res_status_next = ST_FOUND;
                    res_slot_next   = cur_reg;
                    state_next      = S_DONE;
                end
                else if (link_end)
                begin
                    if (mode_reg == MODE_INSERT)
                    begin
                        wr.left_we      = !go_right;
                        wr.right_we     = go_right;
                        res_status_next = ST_INSERTED;
                        res_slot_next   = fresh_reg;
                    end
                    else
                    begin
                        res_status_next = ST_MISSING;
                        res_slot_next   = '0;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    cur_next   = link_sel[NODE_W-1:0];
                    state_next = S_READ;
                end
            end

            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            cap_reg   <= CNT_W'(RESET_CAP);
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            cap_reg   <= cap_next;
        end
    end

    // Working payload of the item in flight
    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        key_reg        <= key_next;
        cur_reg        <= cur_next;
        fresh_reg      <= fresh_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
    end

    // Response register: hold the beat until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
        end
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.status = out_status_reg;
    assign rsp.slot   = out_slot_reg;

    // Stored nodes never outnumber the capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cap_reg)
        else $error("node count exceeds capacity");

    // The walk only visits occupied slots
    a_walk_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> ({1'b0, root - cur_reg} < count_reg))
        else $error("walk reached a free slot");

    // Every compare uses data read in the cycle before
    a_cmp_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> ($past(state_reg) == S_READ))
        else $error("compare without a preceding read");

    // A response beat appears only out of the done state
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("response raised outside done state");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the array-backed binary search tree: inserts and finds.
`timescale 1ns / 100ps

module tb;

    import abst_pkg::*;

    localparam int NODES     = 256;
    localparam int KEY_W     = 32;
    localparam logic [8:0] NO_CHILD = 9'(NODES);  // link value meaning "no child"
    localparam int MAX_ERR_SHOWN = 10;

    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

    typedef struct {
        logic                    mode;
        logic signed [KEY_W-1:0] key;
    } cmd_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [7:0]          slot;
    } answer_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we    = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    abst_in_if  #(.KEY_BITS(KEY_W)) cmd_if ();
    abst_out_if #(.SLOT_W(8))       rsp_if ();

    array_bst_insert_search_top #(
        .MAX_NODES (NODES),
        .KEY_BITS  (KEY_W)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd_if),
        .rsp       (rsp_if)
    );

    // ------------------------------------------------------------------
    // Tree predictor: own copy of the node store, the count and the
    // effective capacity.  Slots are only read once written since the
    // last clear, so no initial contents are needed.
    // ------------------------------------------------------------------
    logic signed [KEY_W-1:0] bst_keys  [NODES];
    logic [8:0]              bst_left  [NODES];
    logic [8:0]              bst_right [NODES];
    int                      bst_count;
    int                      bst_cap;

    // Clamp the written capacity to 1..NODES and empty the tree.
    function automatic void tree_set_capacity(input logic [CFG_W-1:0] v);
        if (v == 0)
            bst_cap = 1;
        else if (v > NODES)
            bst_cap = NODES;
        else
            bst_cap = int'(v);
        bst_count = 0;
    endfunction

    // Apply one command to the model tree and return the answer it gives.
    function automatic answer_t tree_apply(input logic mode,
                                           input logic signed [KEY_W-1:0] key);
        answer_t ans;
        int      root;
        int      cur;
        int      fresh;
        int      steps;
        root       = bst_cap - 1;
        cur        = root;
        ans.status = ST_MISSING;
        ans.slot   = '0;
        if (mode == MODE_INSERT)
        begin
            if (bst_count >= bst_cap)
            begin
                ans.status = ST_FULL;
            end
            else
            begin
                // Slots are handed out downwards from the root
                fresh            = root - bst_count;
                bst_count        = bst_count + 1;
                bst_keys[fresh]  = key;
                bst_left[fresh]  = NO_CHILD;
                bst_right[fresh] = NO_CHILD;
                steps            = 0;
                // Walk from the root; equal keys go right
                while (fresh != root && steps < bst_cap)
                begin
                    if (bst_keys[cur] > key)
                    begin
                        if (bst_left[cur] == NO_CHILD)
                        begin
                            bst_left[cur] = 9'(fresh);
                            break;
                        end
                        cur = int'(bst_left[cur]);
                    end
                    else
                    begin
                        if (bst_right[cur] == NO_CHILD)
                        begin
                            bst_right[cur] = 9'(fresh);
                            break;
                        end
                        cur = int'(bst_right[cur]);
                    end
                    steps++;
                end
                ans.status = ST_INSERTED;
                ans.slot   = fresh[7:0];
            end
        end
        else if (bst_count > 0)
        begin
            steps = 0;
            // Stop at the first equal key met on the walk
            while (steps < bst_cap)
            begin
                if (bst_keys[cur] == key)
                begin
                    ans.status = ST_FOUND;
                    ans.slot   = cur[7:0];
                    break;
                end
                cur = (bst_keys[cur] < key) ? int'(bst_right[cur]) : int'(bst_left[cur]);
                if (cur == int'(NO_CHILD))
                    break;
                steps++;
            end
        end
        return ans;
    endfunction

    // ------------------------------------------------------------------
    // Shared bookkeeping
    // ------------------------------------------------------------------
    cmd_item_t               pending_cmds [$];  // beats still to be offered
    answer_t                 answers_due  [$];  // predicted answers, oldest first
    logic signed [KEY_W-1:0] stored_keys  [$];  // keys inserted since the last clear

    bit gaps_on    = 1'b1;  // let both sides idle between beats
    bit hold_kick  = 1'b0;  // start a long response stall
    int hold_left;

    int n_errors   = 0;
    int n_queued   = 0;
    int n_inserts  = 0;
    int n_finds    = 0;
    int n_hits     = 0;
    int n_full     = 0;
    int n_answers  = 0;
    int n_cfg      = 0;

    function automatic int pick_wait();
        return gaps_on ? $urandom_range(0, 7) : 0;
    endfunction

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        // Hold every input at a known value before the first edge
        rst_n          = 1'b0;
        cmd_if.valid   = 1'b0;
        cmd_if.mode    = MODE_INSERT;
        cmd_if.key     = '0;
        rsp_if.ready   = 1'b0;
        tree_set_capacity(CFG_W'(CAP_RESET));
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Command driver: offer the queued beats, predict each one the moment
    // it is accepted, and idle for a drawn number of cycles after it.
    // ------------------------------------------------------------------
    int cmd_wait;

    always @(posedge clk or negedge rst_n)
    begin : cmd_driver
        cmd_item_t nxt;
        answer_t   ans;
        logic      busy;
        if (!rst_n)
        begin
            cmd_if.valid <= 1'b0;
            cmd_if.mode  <= MODE_INSERT;
            cmd_if.key   <= '0;
            cmd_wait     <= 0;
        end
        else
        begin
            busy = cmd_if.valid && !cmd_if.ready;
            if (cmd_if.valid && cmd_if.ready)
            begin
                ans = tree_apply(cmd_if.mode, cmd_if.key);
                answers_due = {answers_due, ans};
                if (cmd_if.mode == MODE_INSERT)
                    n_inserts++;
                else
                    n_finds++;
                if (ans.status == ST_FOUND)
                    n_hits++;
                if (ans.status == ST_FULL)
                    n_full++;
            end
            // Keep an unaccepted beat on the bus untouched
            if (!busy)
            begin
                if (cmd_wait > 0)
                begin
                    cmd_wait     <= cmd_wait - 1;
                    cmd_if.valid <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    nxt          = pending_cmds.pop_front();
                    cmd_if.valid <= 1'b1;
                    cmd_if.mode  <= nxt.mode;
                    cmd_if.key   <= nxt.key;
                    cmd_wait     <= pick_wait();
                end
                else
                begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    // Long response stall, counted down in its own process
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_kick)
            hold_left <= 400;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // ------------------------------------------------------------------
    // Response monitor: check each accepted beat against the oldest
    // prediction, then drop ready for a drawn number of cycles.
    // ------------------------------------------------------------------
    int rsp_wait;

    always @(posedge clk or negedge rst_n)
    begin : rsp_monitor
        int      nxt;
        answer_t want;
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            rsp_wait     <= 0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                n_answers++;
                if (answers_due.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= MAX_ERR_SHOWN)
                        $display("%0t: unexpected answer status %0d slot %0d",
                                 $realtime, rsp_if.status, rsp_if.slot);
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (rsp_if.status !== want.status || rsp_if.slot !== want.slot)
                    begin
                        n_errors++;
                        if (n_errors <= MAX_ERR_SHOWN)
                            $display("%0t: mismatch: expected status %0d slot %0d,",
                                     $realtime, want.status, want.slot,
                                     " got status %0d slot %0d",
                                     rsp_if.status, rsp_if.slot);
                    end
                end
                nxt = pick_wait();
            end
            else
            begin
                nxt = (rsp_wait > 0) ? rsp_wait - 1 : 0;
            end
            rsp_wait     <= nxt;
            rsp_if.ready <= (nxt == 0) && (hold_left == 0);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.  Queue work at the falling edge; drive the
    // configuration port with nonblocking writes at the rising edge.
    // ------------------------------------------------------------------
    task automatic queue_cmd(input logic mode, input logic signed [KEY_W-1:0] key);
        cmd_item_t it;
        it.mode = mode;
        it.key  = key;
        pending_cmds = {pending_cmds, it};
        n_queued++;
        if (mode == MODE_INSERT)
            stored_keys = {stored_keys, key};
    endtask

    // Wait until every beat is sent and every answer is back
    task automatic drain();
        do
            @(negedge clk);
        while (pending_cmds.size() != 0 || cmd_if.valid || answers_due.size() != 0);
    endtask

    // Write capacity; only called with the block idle.  Clears the tree.
    task automatic write_capacity(input logic [CFG_W-1:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        tree_set_capacity(v);
        stored_keys.delete();
        n_cfg++;
        @(negedge clk);
    endtask

    // Keys: extremes, a narrow band for duplicates, reuse, or full range
    function automatic logic signed [KEY_W-1:0] rand_key();
        case ($urandom_range(0, 9))
            0: return KEY_MIN;
            1: return KEY_MAX;
            2: return $signed($urandom_range(0, 16)) - 8;
            3, 4:
            begin
                if (stored_keys.size() > 0)
                    return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
                return $urandom;
            end
            default: return $urandom;
        endcase
    endfunction

    // One random phase at a given capacity; finds mostly hit stored keys
    task automatic run_phase(input logic [CFG_W-1:0] cap, input int n, input int ins_pct,
                             input bit with_gaps, input bit with_hold);
        int i;
        write_capacity(cap);
        gaps_on = with_gaps;
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(1, 100) <= ins_pct)
                queue_cmd(MODE_INSERT, rand_key());
            else if (stored_keys.size() > 0 && $urandom_range(0, 9) < 7)
                queue_cmd(MODE_FIND, stored_keys[$urandom_range(0, stored_keys.size() - 1)]);
            else
                queue_cmd(MODE_FIND, rand_key());
        end
        // Stall the response side while commands keep coming, so the block
        // backs up and holds its command input
        if (with_hold)
        begin
            hold_kick = 1'b1;
            @(negedge clk);
            hold_kick = 1'b0;
        end
        drain();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int i;
        @(posedge rst_n);
        @(negedge clk);

        // Reset capacity: empty-tree find, extreme keys, duplicates
        queue_cmd(MODE_FIND,   '0);
        queue_cmd(MODE_INSERT, '0);
        queue_cmd(MODE_INSERT, KEY_MAX);
        queue_cmd(MODE_INSERT, KEY_MIN);
        queue_cmd(MODE_INSERT, -1);
        queue_cmd(MODE_INSERT, 1);
        queue_cmd(MODE_INSERT, '0);
        queue_cmd(MODE_INSERT, KEY_MIN);
        queue_cmd(MODE_FIND,   '0);
        queue_cmd(MODE_FIND,   KEY_MAX);
        queue_cmd(MODE_FIND,   KEY_MIN);
        queue_cmd(MODE_FIND,   -1);
        queue_cmd(MODE_FIND,   2);
        queue_cmd(MODE_FIND,   KEY_MIN + 1);
        drain();

        // Single slot: root only, then full
        write_capacity(9'd1);
        queue_cmd(MODE_INSERT, 5);
        queue_cmd(MODE_INSERT, 6);
        queue_cmd(MODE_FIND,   5);
        queue_cmd(MODE_FIND,   6);
        drain();

        // Zero capacity behaves as one slot
        write_capacity(9'd0);
        queue_cmd(MODE_INSERT, KEY_MAX);
        queue_cmd(MODE_INSERT, KEY_MAX);
        drain();

        // Out-of-range capacity clamps to the full store: build a
        // left-leaning chain of maximum depth, overfill it, then search it
        write_capacity(9'd511);
        gaps_on = 1'b0;
        for (i = 0; i < NODES; i++)
            queue_cmd(MODE_INSERT, 1000 - 7 * i);
        for (i = 0; i < 8; i++)
            queue_cmd(MODE_INSERT, rand_key());
        for (i = 0; i < 30; i++)
        begin
            if (i % 5 == 4)
                queue_cmd(MODE_FIND, -2000);
            else
                queue_cmd(MODE_FIND, 1000 - 7 * $urandom_range(0, NODES - 1));
        end
        drain();

        // Random phases across the capacity range
        run_phase(9'd2,   60,  60, 1'b1, 1'b0);
        run_phase(9'd3,   60,  60, 1'b0, 1'b0);
        run_phase(9'd300, 300, 90, 1'b1, 1'b0);
        run_phase(9'd17,  120, 50, 1'b1, 1'b0);
        run_phase(9'd64,  200, 50, 1'b1, 1'b1);
        run_phase(9'd255, 200, 60, 1'b0, 1'b0);
        run_phase(9'd8,   80,  50, 1'b1, 1'b0);
        run_phase(9'd128, 250, 55, 1'b1, 1'b0);
        run_phase(9'd256, 250, 50, 1'b1, 1'b0);
        run_phase(9'd1,   40,  50, 1'b1, 1'b0);
        while (n_queued < 1950)
            run_phase(CFG_W'($urandom_range(0, 511)), $urandom_range(40, 100), 50,
                      1'($urandom_range(0, 1)), 1'b0);

        // Allow a stray late answer to show up before closing
        repeat (600) @(negedge clk);
        if (answers_due.size() != 0)
        begin
            $display("%0d predicted answers never arrived", answers_due.size());
            n_errors += answers_due.size();
        end

        $display("Covered %0d inserts (%0d refused as full) and %0d finds (%0d hits)",
                 n_inserts, n_full, n_finds, n_hits);
        $display("across %0d capacity writes; %0d answers checked, %0d errors",
                 n_cfg, n_answers, n_errors);
        if (n_errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #80_000_000;
        $display("Timeout with %0d commands and %0d answers outstanding",
                 pending_cmds.size(), answers_due.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
